### rtl/printer_command_frame_builder_defines.svh
// Assertion macros shared by the frame builder RTL.
`ifndef PRINTER_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define PRINTER_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pcfb_pkg.sv
// Constants and codes for the serial command frame builder.
package pcfb_pkg;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_DATA  = 1'b1;

    localparam logic [7:0] BYTE_SOH     = 8'h01;
    localparam logic [7:0] BYTE_ENQ     = 8'h05;
    localparam logic [7:0] BYTE_ETX     = 8'h03;
    localparam logic [7:0] LEN_OFFSET   = 8'h24;
    localparam logic [3:0] NIBBLE_HIGH  = 4'h3;
    localparam logic [6:0] SEQ_FIRST    = 7'h20;
    localparam logic [6:0] SEQ_LAST     = 7'h7F;

    // Position of a byte inside a frame; a data transfer starts at SLOT_PAY.
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_SOH = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_LEN = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_SEQ = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_PAY = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_ENQ = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_N3  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_N2  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_N1  = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_N0  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_ETX = 4'd9;

endpackage

### rtl/printer_command_frame_builder.sv
// Serial command frame builder: header, pass-through data and checksum trailer.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_ready   i_command, i_printer_op, i_data_len, i_data_byte
//  output    out        o_valid / i_ready   o_out_byte, o_frame_end, o_run_last, o_error
//
//  Each input transfer yields 1 to 10 output transfers, one per cycle while i_ready
//  is high. A data byte in the middle of a frame yields 1 output byte; the last one
//  yields 7, a start yields 4, or 10 for zero length. The output register sets this pace.
//  A new item is taken in the same cycle the previous item's last byte moves
//  into the output register, so runs of single-byte items flow back to back.
//  Reset is synchronous, active low; it clears the frame state and both valid flags.
//  A stall on i_ready holds the output register and, behind it, the input.
`include "printer_command_frame_builder_defines.svh"

module printer_command_frame_builder
    import pcfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [7:0] i_printer_op,
    input  logic [7:0] i_data_len,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_run_last,
    output logic       o_error
);

    // Frame state.
    logic [6:0]  r_seq;
    logic [15:0] r_sum;
    logic [7:0]  r_rem;
    logic        r_open;

    // Item register: one accepted item being unrolled into bytes.
    logic              r_bv;
    logic [SLOT_W-1:0] r_k;
    logic              r_err;
    logic              r_close;
    logic [7:0]        r_pay;
    logic [7:0]        r_lenb;
    logic [6:0]        r_bseq;
    logic [15:0]       r_csum;

    // Output register.
    logic       r_ov;
    logic [7:0] r_obyte;
    logic       r_oend;
    logic       r_olast;
    logic       r_oerr;

    logic              accept;
    logic              out_load;
    logic              at_last;
    logic [SLOT_W-1:0] last_slot;
    logic [7:0]        slot_byte;
    logic              bad_order;
    logic              closing;
    logic [7:0]        len_byte;
    logic [15:0]       sum_body;
    logic [6:0]        seq_next;
    logic [7:0]        rem_dec;

    assign last_slot = r_close ? SLOT_ETX : SLOT_PAY;
    assign at_last   = (r_k == last_slot);
    assign out_load  = r_bv && (!r_ov || i_ready);
    assign o_ready   = !r_bv || (out_load && at_last);
    assign accept    = i_valid && o_ready;

    assign bad_order = ((i_command == CMD_START) == r_open);
    assign len_byte  = i_data_len + LEN_OFFSET;
    assign rem_dec   = r_rem - 8'd1;
    assign closing   = (i_command == CMD_START) ? (i_data_len == 8'd0) : (rem_dec == 8'd0);
    assign seq_next  = (r_seq == SEQ_LAST) ? SEQ_FIRST : r_seq + 7'd1;

    // Checksum of the frame through the current item, before the closing 0x05.
    always_comb begin
        if (i_command == CMD_START) begin
            sum_body = {8'h00, len_byte} + {9'h000, r_seq} + {8'h00, i_printer_op};
        end else begin
            sum_body = r_sum + {8'h00, i_data_byte};
        end
    end

    always_comb begin
        unique case (r_k)
            SLOT_SOH: slot_byte = BYTE_SOH;
            SLOT_LEN: slot_byte = r_lenb;
            SLOT_SEQ: slot_byte = {1'b0, r_bseq};
            SLOT_PAY: slot_byte = r_err ? 8'h00 : r_pay;
            SLOT_ENQ: slot_byte = BYTE_ENQ;
            SLOT_N3:  slot_byte = {NIBBLE_HIGH, r_csum[15:12]};
            SLOT_N2:  slot_byte = {NIBBLE_HIGH, r_csum[11:8]};
            SLOT_N1:  slot_byte = {NIBBLE_HIGH, r_csum[7:4]};
            SLOT_N0:  slot_byte = {NIBBLE_HIGH, r_csum[3:0]};
            SLOT_ETX: slot_byte = BYTE_ETX;
            default:  slot_byte = 8'h00;
        endcase
    end

    // Frame state is updated when the item is taken, not as its bytes leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= SEQ_FIRST;
            r_sum  <= 16'h0000;
            r_rem  <= 8'h00;
            r_open <= 1'b0;
        end else if (accept && !bad_order) begin
            if (closing) begin
                r_seq  <= seq_next;
                r_sum  <= 16'h0000;
                r_rem  <= 8'h00;
                r_open <= 1'b0;
            end else begin
                r_sum  <= sum_body;
                r_rem  <= (i_command == CMD_START) ? i_data_len : rem_dec;
                r_open <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
            r_k  <= SLOT_SOH;
        end else if (accept) begin
            r_bv <= 1'b1;
            r_k  <= (i_command == CMD_START && !bad_order) ? SLOT_SOH : SLOT_PAY;
        end else if (out_load) begin
            if (at_last) begin
                r_bv <= 1'b0;
            end else begin
                r_k <= r_k + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err   <= bad_order;
            r_close <= closing && !bad_order;
            r_pay   <= (i_command == CMD_START) ? i_printer_op : i_data_byte;
            r_lenb  <= len_byte;
            r_bseq  <= r_seq;
            r_csum  <= sum_body + {8'h00, BYTE_ENQ};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte <= slot_byte;
            r_oend  <= (r_k == SLOT_ETX);
            r_olast <= at_last;
            r_oerr  <= r_err;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_obyte;
    assign o_frame_end = r_oend;
    assign o_run_last  = r_olast;
    assign o_error     = r_oerr;

    `PCFB_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_ov && r_oend, r_olast && !r_oerr, "frame end byte must close its item")
    `PCFB_ASSERT_IMP(a_err_single, i_clk, i_rst_n, r_ov && r_oerr, r_olast && r_obyte == 8'h00, "error result must be a single zero byte")
    `PCFB_ASSERT_IMP(a_open_has_rem, i_clk, i_rst_n, r_open, r_rem != 8'h00, "open frame must expect data")
    `PCFB_ASSERT_IMP(a_busy_blocks, i_clk, i_rst_n, r_bv && !at_last, !o_ready, "input taken before item finished")
    `PCFB_ASSERT_NEXT(a_burst_holds, i_clk, i_rst_n, r_bv && !at_last, r_bv, "item dropped before its last byte")

endmodule

### sim/printer_command_frame_builder_tb.sv
// Self-checking testbench for the serial command frame builder.
`timescale 1ns / 100ps

module printer_command_frame_builder_tb;
    import pcfb_pkg::*;

    typedef struct packed {
        logic       command;
        logic [7:0] printer_op;
        logic [7:0] data_len;
        logic [7:0] data_byte;
        logic [1:0] phase;
        logic       drain;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       run_last;
        logic       error;
    } frame_byte_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_command = 1'b0;
    logic [7:0] i_printer_op = 8'h00;
    logic [7:0] i_data_len = 8'h00;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_frame_end;
    logic       o_run_last;
    logic       o_error;

    printer_command_frame_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_printer_op(i_printer_op),
        .i_data_len  (i_data_len),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_run_last  (o_run_last),
        .o_error     (o_error)
    );

    cmd_item_t   pending_cmds[$];
    frame_byte_t bytes_due[$];

    // Frame state mirrored from the block.
    logic [6:0]  seq_num = SEQ_FIRST;
    logic [15:0] frame_sum = 16'h0000;
    logic [7:0]  bytes_left = 8'h00;
    logic        frame_is_open = 1'b0;

    // Frame state seen by the stimulus generator.
    logic        gen_open = 1'b0;
    logic [7:0]  gen_left = 8'h00;
    logic [1:0]  gen_phase = 2'd0;

    logic        in_took = 1'b0;
    logic [1:0]  cur_phase = 2'd0;

    int failures = 0;
    int items_taken = 0;
    int results_seen = 0;
    int error_results = 0;
    int frames_closed = 0;
    int seq_wraps = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("%0t: run did not complete, %0d results still due", $time, bytes_due.size());
        $display("simulation failed");
        $finish;
    end

    function automatic int idle_pct(input logic rx_side, input logic [1:0] ph);
        case (ph)
            2'd0:    idle_pct = rx_side ? 87 : 18;
            2'd1:    idle_pct = rx_side ? 18 : 87;
            default: idle_pct = 0;
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic summed, input logic ends,
                            input logic last);
        frame_byte_t r;
        if (summed) begin
            frame_sum = frame_sum + {8'h00, b};
        end
        r.tx_byte   = b;
        r.frame_end = ends;
        r.run_last  = last;
        r.error     = 1'b0;
        bytes_due.push_back(r);
    endtask

    task automatic finish_frame();
        put_byte(BYTE_ENQ, 1'b1, 1'b0, 1'b0);
        put_byte({NIBBLE_HIGH, frame_sum[15:12]}, 1'b0, 1'b0, 1'b0);
        put_byte({NIBBLE_HIGH, frame_sum[11:8]}, 1'b0, 1'b0, 1'b0);
        put_byte({NIBBLE_HIGH, frame_sum[7:4]}, 1'b0, 1'b0, 1'b0);
        put_byte({NIBBLE_HIGH, frame_sum[3:0]}, 1'b0, 1'b0, 1'b0);
        put_byte(BYTE_ETX, 1'b0, 1'b1, 1'b1);
        frame_is_open = 1'b0;
        bytes_left    = 8'h00;
        frame_sum     = 16'h0000;
        frames_closed++;
        if (seq_num >= SEQ_LAST) begin
            seq_num = SEQ_FIRST;
            seq_wraps++;
        end else begin
            seq_num = seq_num + 7'd1;
        end
    endtask

    task automatic predict_frame_bytes(input cmd_item_t it);
        frame_byte_t r;
        logic [7:0]  len_byte;
        if ((it.command == CMD_START) == frame_is_open) begin
            // Out-of-order transfer: one error byte, frame state untouched.
            r.tx_byte   = 8'h00;
            r.frame_end = 1'b0;
            r.run_last  = 1'b1;
            r.error     = 1'b1;
            bytes_due.push_back(r);
        end else if (it.command == CMD_START) begin
            len_byte  = it.data_len + LEN_OFFSET;
            frame_sum = 16'h0000;
            put_byte(BYTE_SOH, 1'b0, 1'b0, 1'b0);
            put_byte(len_byte, 1'b1, 1'b0, 1'b0);
            put_byte({1'b0, seq_num}, 1'b1, 1'b0, 1'b0);
            put_byte(it.printer_op, 1'b1, 1'b0, it.data_len != 8'h00);
            if (it.data_len == 8'h00) begin
                finish_frame();
            end else begin
                frame_is_open = 1'b1;
                bytes_left    = it.data_len;
            end
        end else begin
            put_byte(it.data_byte, 1'b1, 1'b0, bytes_left != 8'h01);
            bytes_left = bytes_left - 8'h01;
            if (bytes_left == 8'h00) begin
                finish_frame();
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
            failures++;
        end
    endtask

    task automatic add_cmd(input logic cmd, input logic [7:0] op, input logic [7:0] len,
                           input logic [7:0] db, input logic drain);
        cmd_item_t it;
        it.command    = cmd;
        it.printer_op = op;
        it.data_len   = len;
        it.data_byte  = db;
        it.phase      = gen_phase;
        it.drain      = drain;
        pending_cmds.push_back(it);
    endtask

    task automatic add_start(input logic [7:0] op, input logic [7:0] len, input logic drain);
        add_cmd(CMD_START, op, len, 8'($urandom_range(255)), drain);
        if (!gen_open && len != 8'h00) begin
            gen_open = 1'b1;
            gen_left = len;
        end
    endtask

    task automatic add_data(input logic [7:0] db, input logic drain);
        add_cmd(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)), db, drain);
        if (gen_open) begin
            gen_left = gen_left - 8'h01;
            gen_open = gen_left != 8'h00;
        end
    endtask

    // Driver: a held transfer stays on the bus until taken, else the next one may go out.
    always @(negedge i_clk) begin : drive_cmds
        cmd_item_t nxt;
        logic      go;
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= idle_pct(1'b1, cur_phase));
            if (!(i_valid && !in_took)) begin
                go = 1'b0;
                if (pending_cmds.size() != 0) begin
                    nxt = pending_cmds[0];
                    if (!(nxt.drain && bytes_due.size() != 0)) begin
                        go = ($urandom_range(99) >= idle_pct(1'b0, nxt.phase));
                    end
                end
                if (go) begin
                    void'(pending_cmds.pop_front());
                    i_command    <= nxt.command;
                    i_printer_op <= nxt.printer_op;
                    i_data_len   <= nxt.data_len;
                    i_data_byte  <= nxt.data_byte;
                    cur_phase    <= nxt.phase;
                end
                i_valid <= go;
            end
        end
    end

    // Monitor: predicts on each input transfer, then checks any output transfer.
    always @(posedge i_clk) begin : watch_bus
        cmd_item_t   got_cmd;
        frame_byte_t want;
        if (i_rst_n) begin
            in_took <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                got_cmd.command    = i_command;
                got_cmd.printer_op = i_printer_op;
                got_cmd.data_len   = i_data_len;
                got_cmd.data_byte  = i_data_byte;
                got_cmd.phase      = cur_phase;
                got_cmd.drain      = 1'b0;
                predict_frame_bytes(got_cmd);
                items_taken++;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected output transfer, expected none, actual %02h %b%b%b",
                             $time, o_out_byte, o_frame_end, o_run_last, o_error);
                    failures++;
                end else begin
                    want = bytes_due.pop_front();
                    if (want.error) begin
                        error_results++;
                    end
                    check_field("out_byte", want.tx_byte, o_out_byte);
                    check_field("frame_end", {7'h00, want.frame_end}, {7'h00, o_frame_end});
                    check_field("run_last", {7'h00, want.run_last}, {7'h00, o_run_last});
                    check_field("error", {7'h00, want.error}, {7'h00, o_error});
                end
            end
        end else begin
            in_took <= 1'b0;
        end
    end

    initial begin : stimulus
        int         k;
        int         pick;
        logic       drain;
        logic [7:0] len;

        // Directed part: error cases, zero-length frames and byte extremes.
        add_data(8'hFF, 1'b0);
        add_start(8'h00, 8'h00, 1'b0);
        add_start(8'hFF, 8'h00, 1'b0);
        add_start(8'hA5, 8'd3, 1'b0);
        add_data(8'h00, 1'b0);
        add_start(8'h5A, 8'h00, 1'b0);
        add_data(8'hFF, 1'b0);
        add_data(8'h80, 1'b0);
        add_data(8'h7F, 1'b0);
        add_start(8'h3C, 8'd1, 1'b0);
        add_data(8'h01, 1'b0);
        add_start(8'hC3, 8'd2, 1'b1);
        add_data(8'hFE, 1'b0);
        add_data(8'h55, 1'b0);

        // Random part: mostly well-formed frames with a sprinkling of stray transfers.
        for (k = 0; k < 240; k++) begin
            gen_phase = (k < 80) ? 2'd0 : (k < 160) ? 2'd1 : 2'd2;
            drain = (k == 80) || (k == 160) || ($urandom_range(99) == 0);
            if ($urandom_range(99) < 8) begin
                if (gen_open) begin
                    add_start(8'($urandom_range(255)), 8'($urandom_range(255)), drain);
                end else begin
                    add_data(8'($urandom_range(255)), drain);
                end
            end else if (gen_open) begin
                add_data(8'($urandom_range(255)), drain);
            end else begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    len = 8'h00;
                end else if (pick < 96) begin
                    len = 8'($urandom_range(4, 1));
                end else begin
                    len = 8'($urandom_range(40, 5));
                end
                add_start(8'($urandom_range(255)), len, drain);
            end
        end
        while (gen_open) begin
            add_data(8'($urandom_range(255)), 1'b0);
        end

        // Longest legal frame, then an oversized length whose frame is left open.
        add_start(8'($urandom_range(255)), 8'd219, 1'b1);
        repeat (219) add_data(8'($urandom_range(255)), 1'b0);
        add_start(8'($urandom_range(255)), 8'hFF, 1'b1);
        repeat (3) add_data(8'($urandom_range(255)), 1'b0);
        add_start(8'($urandom_range(255)), 8'h00, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_valid) @(posedge i_clk);
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d input transfers and %0d output bytes: %0d frames closed,",
                 items_taken, results_seen, frames_closed);
        $display("%0d out-of-order transfers flagged, sequence number wrapped %0d times.",
                 error_results, seq_wraps);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
